// File: rtl/he_pkg.sv
// Shared types, constants and helpers for the histogram entropy block.
// No dependencies; imported by he_mul, he_div and histogram_entropy.
`default_nettype none

package he_pkg;

  localparam int BIN_W        = 32;   // bin count field width
  localparam int ENT_W        = 30;   // entropy field width
  localparam int IDX_W        = 16;   // map index width
  localparam int STAT_W       = 2;    // status width
  localparam int SUM_W        = 64;   // weighted log sum width
  localparam int MUL_W        = 32;   // shared multiplier operand width
  localparam int EXP_W        = 5;    // integer part of log2 for 32-bit values
  localparam int FRAC_BITS_D  = 24;
  localparam int COUNT_BITS_D = 32;
  localparam int OUT_DATA_W   = ((ENT_W + IDX_W + 7) / 8) * 8;

  typedef enum logic [STAT_W-1:0] {
    HE_OK   = 2'd0,
    HE_ZERO = 2'd1,
    HE_SAT  = 2'd2
  } he_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_LOG_FIX,
    ST_PROD_MUL,
    ST_PROD_ADD,
    ST_SUM_ADD,
    ST_END,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } he_state_t;

  typedef struct packed {
    logic [EXP_W-1:0] e;   // index of the leading one
    logic [MUL_W-1:0] y;   // value aligned so the leading one sits at bit 31
  } he_norm_t;

  // Align x to a 1.31 value; x must be nonzero.
  function automatic he_norm_t he_normalize(input logic [MUL_W-1:0] x);
    he_norm_t r;
    r.e = EXP_W'(MUL_W - 1);
    r.y = x;
    if (r.y[31:16] == 16'd0) begin
      r.y = r.y << 16;
      r.e = r.e - EXP_W'(16);
    end
    if (r.y[31:24] == 8'd0) begin
      r.y = r.y << 8;
      r.e = r.e - EXP_W'(8);
    end
    if (r.y[31:28] == 4'd0) begin
      r.y = r.y << 4;
      r.e = r.e - EXP_W'(4);
    end
    if (r.y[31:30] == 2'd0) begin
      r.y = r.y << 2;
      r.e = r.e - EXP_W'(2);
    end
    if (r.y[31] == 1'b0) begin
      r.y = r.y << 1;
      r.e = r.e - EXP_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/he_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on he_pkg for the operand width.
`default_nettype none

module he_mul (
  input  wire logic                        clk,
  input  wire logic [he_pkg::MUL_W-1:0]    a,
  input  wire logic [he_pkg::MUL_W-1:0]    b,
  output logic      [2*he_pkg::MUL_W-1:0]  p
);
  import he_pkg::*;

  logic [2*MUL_W-1:0] p_r;

  // product is registered, ready in the cycle after the operands
  always_ff @(posedge clk) begin
    p_r <= (2*MUL_W)'(a) * (2*MUL_W)'(b);
  end

  assign p = p_r;

endmodule

`default_nettype wire

// File: rtl/he_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on he_pkg.
`default_nettype none

module he_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);
  import he_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r, quot_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift in one dividend bit, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (run_r) begin
      quot_r <= {quot_r[NUM_W-2:0], ge};
      rem_r  <= ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r)
    else $error("divider done while still running");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && den_r != '0) |-> (rem_r < den_r))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

// File: rtl/histogram_entropy.sv
// Top level of the histogram entropy block: sequencer, state and output register.
// Depends on he_pkg, he_mul (shared multiplier) and he_div (iterative divider).
//
// Usage:
//   Input channel (in_*): one histogram bin count per item. in_tlast marks the
//   last bin of a map, in_tuser (with in_tlast) marks the last map of a set.
//   Output channel (out_*): one item per map, the entropy of that map in bits
//   with FRAC_BITS fraction bits, its index in the set, a status and out_tlast
//   on the final map of the set.
//   Sequence: a bin count of 0 or 1 skips the log2. A larger count runs the
//   squaring log2 on the shared multiplier, one fraction bit per squaring
//   step, then the count*log2 product and the sum. A map end adds one log2
//   of the total and a restoring divide of the sum by the total; a zero
//   total skips both.
//   in_tready is high only while the sequencer waits for an item.
//   The result sits in an output register; the block keeps accepting bins
//   while it waits, and stalls at the next map end until it has been taken.
//   Reset (rst_n low, synchronous) clears the sums, the latched total and
//   the map index, and empties the output register.
`default_nettype none

module histogram_entropy #(
  parameter int FRAC_BITS  = he_pkg::FRAC_BITS_D,
  parameter int COUNT_BITS = he_pkg::COUNT_BITS_D
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [he_pkg::BIN_W-1:0]        in_tdata,   // [31:0] bin_count
  input  wire logic                            in_tlast,   // end_of_map
  input  wire logic                            in_tuser,   // [0] end_of_set
  // result channel
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [he_pkg::OUT_DATA_W-1:0]   out_tdata,  // [29:0] entropy,
                                                           // [45:30] map_index, rest 0
  output logic                                 out_tlast,  // last_map
  output logic      [he_pkg::STAT_W-1:0]       out_tuser   // [1:0] status
);
  import he_pkg::*;

  localparam int LOG_W  = EXP_W + FRAC_BITS;              // width of a log2 value
  localparam int LOG_XW = MUL_W + 1;                      // log2 padded for the product
  localparam int ITER_W = $clog2(FRAC_BITS);
  localparam int RT_W   = COUNT_BITS + 1;                 // running total incl. cap
  localparam int RS_W   = ((RT_W > BIN_W) ? RT_W : BIN_W) + 1;
  localparam logic [RT_W-1:0] TOTAL_CAP = {1'b1, {COUNT_BITS{1'b0}}};
  localparam logic [SUM_W-1:0] ENT_MAX  = SUM_W'((64'd1 << ENT_W) - 64'd1);

  // sequencer
  he_state_t state_r, state_nxt;

  // item held during its processing
  logic [BIN_W-1:0]     cnt_r;
  logic                 eom_r;
  logic                 eos_r;

  // block state
  logic [SUM_W-1:0]     wls_r;
  logic [RT_W-1:0]      running_r;
  logic [COUNT_BITS-1:0] latched_r;
  logic                 known_r;
  logic [IDX_W-1:0]     map_cnt_r;

  // log2 iteration
  logic                 for_n_r;
  logic [EXP_W-1:0]     exp_r;
  logic [MUL_W-1:0]     y_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [ITER_W-1:0]    iter_r;
  logic [LOG_W-1:0]     ln_r;
  logic [SUM_W-1:0]     prod_r;

  // result in progress and output register
  logic [ENT_W-1:0]     ent_r;
  he_status_t           stat_r;
  logic                 out_valid_r;
  logic [ENT_W-1:0]     out_ent_r;
  logic [IDX_W-1:0]     out_idx_r;
  he_status_t           out_stat_r;
  logic                 out_last_r;

  // datapath nets
  logic                 accept;
  logic                 out_free;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic                 div_start;
  logic                 div_done;
  logic [SUM_W-1:0]     div_q;
  logic [RS_W-1:0]      rt_sum;
  logic [COUNT_BITS-1:0] n_sat;
  logic [COUNT_BITS-1:0] n_eff;
  logic [MUL_W-1:0]     log_x;
  he_norm_t             norm;
  logic [MUL_W:0]       sq;
  logic                 log_done;
  logic [LOG_W-1:0]     log_val;
  logic [LOG_XW-1:0]    log_ext;
  logic [SUM_W:0]       prod_sum;
  logic [SUM_W:0]       wls_sum;
  logic [SUM_W-1:0]     ent_diff;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // running total of the first map, capped
  assign rt_sum = RS_W'(running_r) + RS_W'(in_tdata);
  assign n_sat  = (running_r > RT_W'(TOTAL_CAP - RT_W'(1))) ?
                  {COUNT_BITS{1'b1}} : running_r[COUNT_BITS-1:0];
  assign n_eff  = known_r ? latched_r : n_sat;

  // log2 datapath
  assign log_x    = for_n_r ? MUL_W'(latched_r) : cnt_r;
  assign norm     = he_normalize(log_x);
  assign sq       = mul_p[2*MUL_W-1:MUL_W-1];
  assign log_done = (iter_r == ITER_W'(FRAC_BITS - 1));
  assign log_val  = {exp_r, frac_r};
  assign log_ext  = LOG_XW'(log_val);

  // saturating product and sum
  assign prod_sum = {1'b0, mul_p} + (log_ext[MUL_W] ? {1'b0, cnt_r, {MUL_W{1'b0}}} : '0);
  assign wls_sum  = {1'b0, wls_r} + {1'b0, prod_r};
  assign ent_diff = SUM_W'(ln_r) - div_q;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata > BIN_W'(1)) state_nxt = ST_LOG_NORM;
          else if (in_tlast)        state_nxt = ST_END;
        end
      end
      ST_LOG_NORM:  state_nxt = ST_LOG_SQ;
      ST_LOG_SQ:    state_nxt = ST_LOG_FIX;
      ST_LOG_FIX: begin
        if (log_done) state_nxt = for_n_r ? ST_DIV_START : ST_PROD_MUL;
        else          state_nxt = ST_LOG_SQ;
      end
      ST_PROD_MUL:  state_nxt = ST_PROD_ADD;
      ST_PROD_ADD:  state_nxt = ST_SUM_ADD;
      ST_SUM_ADD:   state_nxt = eom_r ? ST_END : ST_IDLE;
      ST_END:       state_nxt = (n_eff == '0) ? ST_EMIT : ST_LOG_NORM;
      ST_DIV_START: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    mul_a     = cnt_r;
    mul_b     = log_ext[MUL_W-1:0];
    case (state_r)
      ST_IDLE:      in_tready = 1'b1;
      ST_LOG_SQ: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      ST_DIV_START: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // block state: sums, totals, map index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wls_r     <= '0;
      running_r <= '0;
      latched_r <= '0;
      known_r   <= 1'b0;
      map_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          // accumulate the total only until it is latched
          if (accept && !known_r)
            running_r <= (rt_sum > RS_W'(TOTAL_CAP)) ? TOTAL_CAP : rt_sum[RT_W-1:0];
        end
        ST_SUM_ADD:
          wls_r <= wls_sum[SUM_W] ? {SUM_W{1'b1}} : wls_sum[SUM_W-1:0];
        ST_END: begin
          if (!known_r) begin
            latched_r <= n_sat;
            known_r   <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            wls_r <= '0;
            if (eos_r) begin
              running_r <= '0;
              latched_r <= '0;
              known_r   <= 1'b0;
              map_cnt_r <= '0;
            end else begin
              map_cnt_r <= map_cnt_r + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // item registers and log2 / result datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_r   <= in_tdata;
          eom_r   <= in_tlast;
          eos_r   <= in_tuser;
          for_n_r <= 1'b0;
        end
      end
      ST_LOG_NORM: begin
        exp_r  <= norm.e;
        y_r    <= norm.y;
        frac_r <= '0;
        iter_r <= '0;
      end
      ST_LOG_FIX: begin
        // square landed at 2.0 or above: take a one bit and halve
        frac_r <= {frac_r[FRAC_BITS-2:0], sq[MUL_W]};
        y_r    <= sq[MUL_W] ? sq[MUL_W:1] : sq[MUL_W-1:0];
        iter_r <= iter_r + ITER_W'(1);
      end
      ST_PROD_ADD:
        prod_r <= prod_sum[SUM_W] ? {SUM_W{1'b1}} : prod_sum[SUM_W-1:0];
      ST_END: begin
        for_n_r <= 1'b1;
        ent_r   <= '0;
        if (n_eff == '0)                 stat_r <= HE_ZERO;
        else if (running_r == TOTAL_CAP) stat_r <= HE_SAT;
        else                             stat_r <= HE_OK;
      end
      ST_DIV_START:
        ln_r <= log_val;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_q >= SUM_W'(ln_r))  ent_r <= '0;
          else if (ent_diff > ENT_MAX) ent_r <= {ENT_W{1'b1}};
          else                         ent_r <= ent_diff[ENT_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && out_free) begin
      out_ent_r  <= ent_r;
      out_idx_r  <= map_cnt_r;
      out_stat_r <= stat_r;
      out_last_r <= eos_r;
    end
  end

  he_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  he_div #(
    .NUM_W (SUM_W),
    .DEN_W (MUL_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (wls_r),
    .den   (MUL_W'(latched_r)),
    .done  (div_done),
    .quot  (div_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_idx_r, out_ent_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> out_tvalid)
    else $error("result not presented after emit");

  a_latch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !known_r |-> (latched_r == '0))
    else $error("latched total set without a known total");

  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    running_r <= TOTAL_CAP)
    else $error("running total above cap");

  a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_WAIT && latched_r != '0))
    else $error("divider finished outside the map end sequence");

endmodule

`default_nettype wire
